@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/pssc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pssc_pkg;

    localparam int PID_W   = 64;
    localparam int IDX_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CYC_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W   = 32;
    localparam int STEP_W  = $clog2(PID_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_CYCLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 3'd4;

    // status of the bit-serial remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } rem_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/pulse_synced_sequence_start_control.sv @@
// flow: input captured, evaluated, then the result registered; a start alignment
//   search adds a 64-step bit-serial remainder of pulse_id + 3 before the result
// a new input is accepted only once the previous item's result is registered;
//   a waiting result does not block the next input
// reset: aresetn synchronous active low; controller idle, counters and pulse
//   history cleared, registers back to defaults (divisor 1)
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pulse_synced_sequence_start_control (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_we,
    input  wire logic [pssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pssc_pkg::CFG_W-1:0]      cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_start_req,
    input  wire logic                            s_stop_req,
    input  wire logic [pssc_pkg::IDX_W-1:0]      s_seq_index,
    input  wire logic                            s_running_flag,
    input  wire logic [pssc_pkg::PID_W-1:0]      s_pulse_id,
    input  wire logic [pssc_pkg::PID_W-1:0]      s_started_at_pid,
    input  wire logic                            s_load_pending,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_start_req_next,
    output logic                                 m_stop_req_next,
    output logic [pssc_pkg::IDX_W-1:0]           m_seq_index_next,
    output logic [pssc_pkg::IDX_W-1:0]           m_seq_index_global,
    output logic                                 m_running_next,
    output logic [pssc_pkg::PID_W-1:0]           m_started_at_next,
    output logic                                 m_load_seq,
    output logic                                 m_load_pending_next,
    output logic                                 m_enable_events
);
    import pssc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_DONE} fsm_t;

    typedef enum logic [2:0] {
        CS_IDLE    = 3'd0,
        CS_ARMED   = 3'd1,
        CS_RUNNING = 3'd2,
        CS_STARTED = 3'd3,
        CS_STOPPED = 3'd4
    } ctrl_t;

    // configuration
    logic [IDX_W-1:0] seq_length_reg;
    logic [CYC_W-1:0] repeat_cycles_reg;
    logic             start_mode_reg;
    logic [DIV_W-1:0] start_divisor_reg;
    logic [DIV_W-1:0] start_offset_reg;

    // captured item
    logic             in_start_reg;
    logic             in_stop_reg;
    logic [IDX_W-1:0] in_index_reg;
    logic             in_running_reg;
    logic [PID_W-1:0] in_pid_reg;
    logic [PID_W-1:0] in_started_reg;
    logic             in_pending_reg;

    // controller state
    fsm_t             state_reg;
    ctrl_t            ctrl_reg;
    logic [CYC_W-1:0] cycle_count_reg;
    logic [PID_W-1:0] seen_pid_reg;
    logic [PID_W-1:0] aligned_pid_reg;
    logic             aligned_valid_reg;

    // evaluation stage
    ctrl_t            st_pre_reg;
    logic [PID_W-1:0] ahead_reg;
    logic             consec_reg;
    logic [IDX_W-1:0] idx_inc_reg;
    logic             need_div_reg;

    // result register
    logic             m_valid_reg;
    logic             o_start_reg;
    logic             o_stop_reg;
    logic [IDX_W-1:0] o_index_reg;
    logic [IDX_W-1:0] o_global_reg;
    logic             o_running_reg;
    logic [PID_W-1:0] o_started_reg;
    logic             o_load_reg;
    logic             o_pending_reg;
    logic             o_enable_reg;

    logic             in_fire;
    logic             done_fire;
    logic             done_wait;
    logic             active;
    ctrl_t            st_pre;
    logic [PID_W-1:0] ahead;
    logic             need_div;
    logic             div_start;
    rem_stat_t        div_stat;

    ctrl_t            st_fin;
    logic [CYC_W-1:0] cyc_inc;
    logic [PID_W-1:0] ahead_diff;
    logic             capture;
    logic             hit;
    logic             o_start, o_stop, o_running, o_load, o_pending, o_enable;
    logic [IDX_W-1:0] o_index, o_global;
    logic [PID_W-1:0] o_started;
    logic [CYC_W-1:0] cycle_next;
    logic [PID_W-1:0] seen_pid_next;
    logic [PID_W-1:0] aligned_pid_next;
    logic             aligned_valid_next;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign done_fire = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign done_wait = (state_reg == S_DONE) && m_valid_reg;
    assign active    = (seq_length_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg    <= '0;
            repeat_cycles_reg <= '0;
            start_mode_reg    <= 1'b0;
            start_divisor_reg <= DIV_W'(1);
            start_offset_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SEQ_LENGTH:    seq_length_reg    <= cfg_data[IDX_W-1:0];
                CFG_REPEAT_CYCLES: repeat_cycles_reg <= cfg_data[CYC_W-1:0];
                CFG_START_MODE:    start_mode_reg    <= cfg_data[0];
                CFG_START_DIVISOR: start_divisor_reg <= cfg_data[DIV_W-1:0];
                CFG_START_OFFSET:  start_offset_reg  <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // request priority: stop, then start while armed or started, then running
    always_comb begin
        if (in_stop_reg) begin
            st_pre = CS_STOPPED;
        end else if (in_start_reg && (ctrl_reg == CS_ARMED || ctrl_reg == CS_STARTED)) begin
            st_pre = CS_STARTED;
        end else if (in_running_reg) begin
            st_pre = CS_RUNNING;
        end else if (ctrl_reg != CS_ARMED) begin
            st_pre = CS_IDLE;
        end else begin
            st_pre = CS_ARMED;
        end
    end

    assign ahead     = in_pid_reg + PID_W'(3);
    assign need_div  = active && (st_pre == CS_STARTED) && start_mode_reg && !aligned_valid_reg;
    assign div_start = (state_reg == S_EVAL) && need_div;

    pssc_rem_serial u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ahead),
        .divisor  (start_divisor_reg),
        .stat     (div_stat)
    );

    assign cyc_inc    = cycle_count_reg + CYC_W'(1);
    assign ahead_diff = ahead_reg - aligned_pid_reg;
    assign capture    = need_div_reg && div_stat.rem_zero;
    // a fresh capture makes the distance zero
    assign hit = !start_mode_reg ||
                 (capture ? (start_offset_reg == '0)
                          : (ahead_diff == {{(PID_W-DIV_W){1'b0}}, start_offset_reg}));

    always_comb begin
        o_start            = in_start_reg;
        o_stop             = in_stop_reg;
        o_index            = in_index_reg;
        o_global           = in_index_reg;
        o_running          = in_running_reg;
        o_started          = in_started_reg;
        o_load             = 1'b0;
        o_pending          = in_pending_reg;
        o_enable           = 1'b0;
        st_fin             = ctrl_reg;
        cycle_next         = cycle_count_reg;
        seen_pid_next      = seen_pid_reg;
        aligned_pid_next   = aligned_pid_reg;
        aligned_valid_next = aligned_valid_reg;
        if (active) begin
            st_fin = st_pre_reg;
            unique case (st_pre_reg)
                CS_STOPPED: begin
                    o_running          = 1'b0;
                    o_index            = '0;
                    o_global           = '0;
                    o_stop             = 1'b0;
                    cycle_next         = '0;
                    aligned_pid_next   = '0;
                    aligned_valid_next = 1'b0;
                end
                CS_RUNNING: begin
                    o_index  = idx_inc_reg;
                    o_global = idx_inc_reg;
                    o_enable = 1'b1;
                    if (idx_inc_reg >= seq_length_reg) begin
                        cycle_next = cyc_inc;
                        if (repeat_cycles_reg != '0 && cyc_inc >= repeat_cycles_reg) begin
                            st_fin    = CS_STOPPED;
                            o_stop    = 1'b1;
                            o_running = 1'b0;
                            o_enable  = 1'b0;
                        end else begin
                            o_index = '0;
                        end
                    end
                    if (ctrl_reg == CS_STARTED) begin
                        o_started = in_pid_reg + PID_W'(2);
                    end
                end
                CS_STARTED: begin
                    if (capture) begin
                        aligned_pid_next   = ahead_reg;
                        aligned_valid_next = 1'b1;
                    end
                    if (hit) begin
                        o_enable  = 1'b1;
                        o_running = 1'b1;
                        o_start   = 1'b0;
                    end
                end
                default: begin
                    // idle or armed: hand off a pending load, track pulse ids
                    if (in_pending_reg) begin
                        o_load    = 1'b1;
                        o_pending = 1'b0;
                    end
                    st_fin        = consec_reg ? CS_ARMED : CS_IDLE;
                    seen_pid_next = in_pid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            ctrl_reg          <= CS_IDLE;
            cycle_count_reg   <= '0;
            seen_pid_reg      <= '0;
            aligned_pid_reg   <= '0;
            aligned_valid_reg <= 1'b0;
            need_div_reg      <= 1'b0;
            st_pre_reg        <= CS_IDLE;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !done_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        in_start_reg   <= s_start_req;
                        in_stop_reg    <= s_stop_req;
                        in_index_reg   <= s_seq_index;
                        in_running_reg <= s_running_flag;
                        in_pid_reg     <= s_pulse_id;
                        in_started_reg <= s_started_at_pid;
                        in_pending_reg <= s_load_pending;
                        state_reg      <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    st_pre_reg   <= st_pre;
                    ahead_reg    <= ahead;
                    consec_reg   <= (in_pid_reg == seen_pid_reg + PID_W'(1));
                    idx_inc_reg  <= in_index_reg + IDX_W'(1);
                    need_div_reg <= need_div;
                    state_reg    <= need_div ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        ctrl_reg          <= st_fin;
                        cycle_count_reg   <= cycle_next;
                        seen_pid_reg      <= seen_pid_next;
                        aligned_pid_reg   <= aligned_pid_next;
                        aligned_valid_reg <= aligned_valid_next;
                        o_start_reg       <= o_start;
                        o_stop_reg        <= o_stop;
                        o_index_reg       <= o_index;
                        o_global_reg      <= o_global;
                        o_running_reg     <= o_running;
                        o_started_reg     <= o_started;
                        o_load_reg        <= o_load;
                        o_pending_reg     <= o_pending;
                        o_enable_reg      <= o_enable;
                        m_valid_reg       <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_start_req_next    = o_start_reg;
    assign m_stop_req_next     = o_stop_reg;
    assign m_seq_index_next    = o_index_reg;
    assign m_seq_index_global  = o_global_reg;
    assign m_running_next      = o_running_reg;
    assign m_started_at_next   = o_started_reg;
    assign m_load_seq          = o_load_reg;
    assign m_load_pending_next = o_pending_reg;
    assign m_enable_events     = o_enable_reg;

    `ASSERT_NEXT(a_accept_eval, aclk, aresetn, in_fire, state_reg == S_EVAL)
    `ASSERT_NEXT(a_hold_done, aclk, aresetn, done_wait && !m_ready, done_wait)
    `ASSERT_IMPLIES(a_div_free, aclk, aresetn, div_start, !div_stat.busy)
    `ASSERT_IMPLIES(a_div_owned, aclk, aresetn, div_stat.busy, state_reg == S_DIV)

endmodule

`default_nettype wire

@@ hw/rtl/pssc_rem_serial.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pssc_rem_serial (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [pssc_pkg::PID_W-1:0]  dividend,
    input  wire logic [pssc_pkg::DIV_W-1:0]  divisor,
    output pssc_pkg::rem_stat_t              stat
);
    import pssc_pkg::*;

    logic [PID_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              fits;
    logic [DIV_W-1:0]  rem_next;

    // one quotient bit per cycle, dividend msb first
    assign trial    = {rem_reg, dvd_reg[PID_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});
    assign rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= DIV_W'(1);
            dvd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(PID_W - 1);
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                div_reg  <= (divisor == '0) ? DIV_W'(1) : divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[PID_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg && !done_reg)
    `ASSERT_IMPLIES(a_rem_bound, aclk, aresetn, busy_reg || done_reg, rem_reg < div_reg)
    `ASSERT_NEXT(a_done_once, aclk, aresetn, done_reg && !start, !done_reg && !busy_reg)

endmodule

`default_nettype wire

@@ tb/tb_pulse_synced_sequence_start_control.sv @@
`timescale 1ns / 1ps

module tb_pulse_synced_sequence_start_control;
    import pssc_pkg::*;

    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD    = 200;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ARMED   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_STARTED = 3'd3,
        ST_STOPPED = 3'd4
    } ctl_state_e;

    typedef struct {
        logic             start_req;
        logic             stop_req;
        logic [IDX_W-1:0] seq_index;
        logic             running_flag;
        logic [PID_W-1:0] pulse_id;
        logic [PID_W-1:0] started_at_pid;
        logic             load_pending;
    } pulse_item_t;

    typedef struct {
        logic             start_req_next;
        logic             stop_req_next;
        logic [IDX_W-1:0] seq_index_next;
        logic [IDX_W-1:0] seq_index_global;
        logic             running_next;
        logic [PID_W-1:0] started_at_next;
        logic             load_seq;
        logic             load_pending_next;
        logic             enable_events;
    } pulse_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        pulse_item_t          item;
        bit                   typed;
        pulse_result_t        want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_start_req = 1'b0;
    logic                 s_stop_req = 1'b0;
    logic [IDX_W-1:0]     s_seq_index = '0;
    logic                 s_running_flag = 1'b0;
    logic [PID_W-1:0]     s_pulse_id = '0;
    logic [PID_W-1:0]     s_started_at_pid = '0;
    logic                 s_load_pending = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_start_req_next;
    logic                 m_stop_req_next;
    logic [IDX_W-1:0]     m_seq_index_next;
    logic [IDX_W-1:0]     m_seq_index_global;
    logic                 m_running_next;
    logic [PID_W-1:0]     m_started_at_next;
    logic                 m_load_seq;
    logic                 m_load_pending_next;
    logic                 m_enable_events;

    // register copies
    logic [CFG_W-1:0] seq_len_r = '0;
    logic [CYC_W-1:0] repeats_r = '0;
    logic             mode_r = 1'b0;
    logic [CFG_W-1:0] divisor_r = 32'd1;
    logic [CFG_W-1:0] offset_r = '0;

    // controller state as seen by the predictor
    ctl_state_e       ctl_st = ST_IDLE;
    logic [CYC_W-1:0] cycle_cnt = '0;
    logic [PID_W-1:0] last_seen_pid = '0;
    logic [PID_W-1:0] aligned_pid = '0;
    bit               aligned_ok = 1'b0;

    pulse_result_t pulse_results_due[$];
    pulse_result_t last_out;
    pulse_result_t seen_want;
    logic [PID_W-1:0] prev_sent_pid = '0;
    dir_row_t dir_rows[$];
    bit steady = 1'b0;
    int holds_asked = 0;
    int holds_served = 0;
    int mismatches = 0;

    pulse_synced_sequence_start_control u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_start_req        (s_start_req),
        .s_stop_req         (s_stop_req),
        .s_seq_index        (s_seq_index),
        .s_running_flag     (s_running_flag),
        .s_pulse_id         (s_pulse_id),
        .s_started_at_pid   (s_started_at_pid),
        .s_load_pending     (s_load_pending),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_start_req_next   (m_start_req_next),
        .m_stop_req_next    (m_stop_req_next),
        .m_seq_index_next   (m_seq_index_next),
        .m_seq_index_global (m_seq_index_global),
        .m_running_next     (m_running_next),
        .m_started_at_next  (m_started_at_next),
        .m_load_seq         (m_load_seq),
        .m_load_pending_next(m_load_pending_next),
        .m_enable_events    (m_enable_events)
    );

    always #1 aclk = ~aclk;

    function automatic pulse_result_t sequencer_step(pulse_item_t it);
        pulse_result_t    r;
        ctl_state_e       st;
        ctl_state_e       st_was;
        logic [IDX_W-1:0] nx;
        logic [PID_W-1:0] ahead;
        logic [PID_W-1:0] div;
        r.start_req_next    = it.start_req;
        r.stop_req_next     = it.stop_req;
        r.seq_index_next    = it.seq_index;
        r.seq_index_global  = it.seq_index;
        r.running_next      = it.running_flag;
        r.started_at_next   = it.started_at_pid;
        r.load_seq          = 1'b0;
        r.load_pending_next = it.load_pending;
        r.enable_events     = 1'b0;
        if (seq_len_r == '0) return r;

        st_was = ctl_st;
        st = ctl_st;
        if (it.stop_req) st = ST_STOPPED;
        else if (it.start_req && (st == ST_ARMED || st == ST_STARTED)) st = ST_STARTED;
        else if (it.running_flag) st = ST_RUNNING;
        else if (st != ST_ARMED) st = ST_IDLE;

        case (st)
            ST_STOPPED: begin
                r.running_next     = 1'b0;
                r.seq_index_next   = '0;
                r.seq_index_global = '0;
                r.stop_req_next    = 1'b0;
                cycle_cnt   = '0;
                aligned_pid = '0;
                aligned_ok  = 1'b0;
            end
            ST_RUNNING: begin
                nx = it.seq_index + 1'b1;
                r.seq_index_next   = nx;
                r.seq_index_global = nx;
                if (nx >= seq_len_r) begin
                    cycle_cnt = cycle_cnt + 1'b1;
                    // repeat count used up: stop and raise the stop button
                    if (repeats_r != '0 && cycle_cnt >= repeats_r) begin
                        st = ST_STOPPED;
                        r.stop_req_next = 1'b1;
                        r.running_next  = 1'b0;
                    end else begin
                        r.seq_index_next = '0;
                        r.enable_events  = 1'b1;
                    end
                end else begin
                    r.enable_events = 1'b1;
                end
                if (st_was == ST_STARTED) r.started_at_next = it.pulse_id + 64'd2;
            end
            ST_STARTED: begin
                ahead = it.pulse_id + 64'd3;
                div = (divisor_r == '0) ? 64'd1 : {32'd0, divisor_r};
                if (mode_r && !aligned_ok && (ahead % div) == '0) begin
                    aligned_pid = ahead;
                    aligned_ok  = 1'b1;
                end
                if (!mode_r || (ahead - aligned_pid) == {32'd0, offset_r}) begin
                    r.enable_events  = 1'b1;
                    r.running_next   = 1'b1;
                    r.start_req_next = 1'b0;
                end
            end
            default: begin
                if (it.load_pending) begin
                    r.load_seq          = 1'b1;
                    r.load_pending_next = 1'b0;
                end
                st = (it.pulse_id == last_seen_pid + 64'd1) ? ST_ARMED : ST_IDLE;
                last_seen_pid = it.pulse_id;
            end
        endcase
        ctl_st = st;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed   = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t pulse_row(bit st, bit sp, logic [IDX_W-1:0] ix, bit rn,
                                           logic [PID_W-1:0] pid, logic [PID_W-1:0] sat,
                                           bit pd);
        dir_row_t r;
        r.is_cfg              = 1'b0;
        r.reg_idx             = '0;
        r.reg_val             = '0;
        r.item.start_req      = st;
        r.item.stop_req       = sp;
        r.item.seq_index      = ix;
        r.item.running_flag   = rn;
        r.item.pulse_id       = pid;
        r.item.started_at_pid = sat;
        r.item.load_pending   = pd;
        r.typed               = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t known_row(dir_row_t base, bit st, bit sp,
                                           logic [IDX_W-1:0] ix, logic [IDX_W-1:0] gl,
                                           bit rn, logic [PID_W-1:0] sat, bit ld, bit pd,
                                           bit en);
        dir_row_t r;
        r = base;
        r.typed                  = 1'b1;
        r.want.start_req_next    = st;
        r.want.stop_req_next     = sp;
        r.want.seq_index_next    = ix;
        r.want.seq_index_global  = gl;
        r.want.running_next      = rn;
        r.want.started_at_next   = sat;
        r.want.load_seq          = ld;
        r.want.load_pending_next = pd;
        r.want.enable_events     = en;
        return r;
    endfunction

    // mostly the pulse that follows the last one with its results fed back,
    // now and then a jump, a repeated pulse id or random noise
    function automatic pulse_item_t build_pulse();
        pulse_item_t it;
        int          roll;
        roll = $urandom_range(0, 99);
        it.pulse_id       = prev_sent_pid + 64'd1;
        it.start_req      = last_out.start_req_next | ($urandom_range(0, 7) == 0);
        it.stop_req       = last_out.stop_req_next | ($urandom_range(0, 59) == 0);
        it.seq_index      = last_out.seq_index_next;
        it.running_flag   = last_out.running_next;
        it.started_at_pid = last_out.started_at_next;
        it.load_pending   = last_out.load_pending_next | ($urandom_range(0, 9) == 0);
        if (roll >= 97) begin
            it.pulse_id = {$urandom, $urandom};
        end else if (roll >= 94) begin
            it.pulse_id = prev_sent_pid;
        end else if (roll >= 85) begin
            it.start_req      = 1'($urandom_range(0, 1));
            it.stop_req       = 1'($urandom_range(0, 1));
            it.seq_index      = $urandom;
            it.running_flag   = 1'($urandom_range(0, 1));
            it.pulse_id       = {$urandom, $urandom};
            it.started_at_pid = {$urandom, $urandom};
            it.load_pending   = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_SEQ_LENGTH:    seq_len_r = val;
            CFG_REPEAT_CYCLES: repeats_r = val[CYC_W-1:0];
            CFG_START_MODE:    mode_r    = val[0];
            CFG_START_DIVISOR: divisor_r = val;
            CFG_START_OFFSET:  offset_r  = val;
            default: ;
        endcase
    endtask

    task automatic settle_block(int extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pulse_results_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic offer_pulse(pulse_item_t it, bit typed, pulse_result_t known);
        int            gap;
        pulse_result_t got;
        gap = 0;
        if (!steady && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_start_req      = it.start_req;
        s_stop_req       = it.stop_req;
        s_seq_index      = it.seq_index;
        s_running_flag   = it.running_flag;
        s_pulse_id       = it.pulse_id;
        s_started_at_pid = it.started_at_pid;
        s_load_pending   = it.load_pending;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = sequencer_step(it);
        if (typed) pulse_results_due.push_back(known);
        else pulse_results_due.push_back(got);
        last_out = got;
        prev_sent_pid = it.pulse_id;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stall bursts, plus a long hold when the sender asks
    initial begin
        int burst;
        forever begin
            @(negedge aclk);
            if (holds_asked != holds_served) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                holds_served++;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13);
                m_ready = 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pulse_results_due.size() == 0) begin
                $display("%0t: result transfer with nothing pending", $time);
                mismatches++;
            end else begin
                seen_want = pulse_results_due.pop_front();
                check_field("start_req_next", seen_want.start_req_next, m_start_req_next);
                check_field("stop_req_next", seen_want.stop_req_next, m_stop_req_next);
                check_field("seq_index_next", seen_want.seq_index_next, m_seq_index_next);
                check_field("seq_index_global", seen_want.seq_index_global,
                            m_seq_index_global);
                check_field("running_next", seen_want.running_next, m_running_next);
                check_field("started_at_next", seen_want.started_at_next,
                            m_started_at_next);
                check_field("load_seq", seen_want.load_seq, m_load_seq);
                check_field("load_pending_next", seen_want.load_pending_next,
                            m_load_pending_next);
                check_field("enable_events", seen_want.enable_events, m_enable_events);
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] len_v;
        logic [CFG_W-1:0] rep_v;
        logic [CFG_W-1:0] mode_v;
        logic [CFG_W-1:0] div_v;
        logic [CFG_W-1:0] off_v;

        dir_rows = '{
            // zero length: everything passes straight through
            known_row(pulse_row(1, 1, '1, 1, '1, '1, 1), 1, 1, '1, '1, 1, '1, 0, 1, 0),
            known_row(pulse_row(0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0, 0, 0),
            cfg_row(CFG_SEQ_LENGTH, 32'd2),
            cfg_row(CFG_REPEAT_CYCLES, 32'd2),
            // idle hands the pending load over
            known_row(pulse_row(0, 0, 0, 0, 64'd10, 0, 1), 0, 0, 0, 0, 0, 0, 1, 0, 0),
            pulse_row(0, 0, 0, 0, 64'd11, 0, 0),
            pulse_row(1, 0, 0, 0, 64'd12, 0, 0),
            pulse_row(0, 0, 32'd0, 1, 64'd13, 0, 0),
            pulse_row(0, 0, 32'd1, 1, 64'd14, 64'd15, 0),
            pulse_row(0, 0, 32'd0, 1, 64'd15, 64'd15, 0),
            pulse_row(0, 0, 32'd1, 1, 64'd16, 64'd15, 0),
            known_row(pulse_row(0, 1, 32'd2, 0, 64'd17, 64'd15, 1),
                      0, 0, 0, 0, 0, 64'd15, 0, 1, 0),
            cfg_row(CFG_START_MODE, 32'd1),
            cfg_row(CFG_START_DIVISOR, 32'd5),
            cfg_row(CFG_START_OFFSET, 32'd2),
            cfg_row(CFG_REPEAT_CYCLES, 32'd0),
            pulse_row(0, 0, 0, 0, 64'd20, 64'd15, 0),
            pulse_row(0, 0, 0, 0, 64'd21, 64'd15, 0),
            pulse_row(1, 0, 0, 0, 64'd22, 64'd15, 0),
            pulse_row(1, 0, 0, 0, 64'd23, 64'd15, 0),
            pulse_row(1, 0, 0, 0, 64'd24, 64'd15, 0),
            pulse_row(0, 0, 0, 1, 64'd25, 64'd15, 0),
            pulse_row(0, 1, 32'd1, 1, 64'd26, 64'd27, 0),
            // zero divisor acts as one; pulse id wraps through the look-ahead
            cfg_row(CFG_START_DIVISOR, 32'd0),
            cfg_row(CFG_START_OFFSET, 32'hFFFF_FFFF),
            pulse_row(0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFD, 64'd27, 0),
            pulse_row(0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd27, 0),
            pulse_row(1, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd27, 0),
            pulse_row(1, 0, 0, 0, 64'd0, 64'd27, 0),
            pulse_row(1, 1, 0, 0, 64'd1, 64'd27, 0),
            cfg_row(CFG_START_MODE, 32'd0),
            // index wraps at 32 bits while running
            pulse_row(0, 0, '1, 1, 64'd2, 64'd27, 0)
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                if (i == 0 || !dir_rows[i-1].is_cfg) settle_block(DRAIN_CYCLES);
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                offer_pulse(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                len_v = 32'hFFFF_FFFF;
                rep_v = 32'd65535;
                mode_v = 32'd1;
                div_v = 32'd1;
                off_v = 32'd0;
            end else if (ph == 1) begin
                len_v = $urandom_range(1, 4);
                rep_v = 32'd1;
                mode_v = 32'd1;
                div_v = 32'hFFFF_FFFF;
                off_v = $urandom_range(0, 3);
            end else begin
                case ($urandom_range(0, 9))
                    0: len_v = 32'd0;
                    1: len_v = 32'hFFFF_FFFF;
                    2: len_v = $urandom;
                    default: len_v = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: rep_v = 32'd0;
                    3: rep_v = 32'd65535;
                    4: rep_v = $urandom_range(0, 65535);
                    default: rep_v = $urandom_range(1, 4);
                endcase
                mode_v = $urandom_range(0, 1);
                case ($urandom_range(0, 9))
                    6: div_v = 32'hFFFF_FFFF;
                    7: div_v = $urandom;
                    8, 9: div_v = 32'd1;
                    default: div_v = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 9))
                    7: off_v = 32'hFFFF_FFFF;
                    8: off_v = $urandom;
                    9: off_v = 32'd0;
                    default: off_v = $urandom_range(0, 10);
                endcase
            end
            settle_block(DRAIN_CYCLES);
            write_reg(CFG_SEQ_LENGTH, len_v);
            write_reg(CFG_REPEAT_CYCLES, rep_v);
            write_reg(CFG_START_MODE, mode_v);
            write_reg(CFG_START_DIVISOR, div_v);
            write_reg(CFG_START_OFFSET, off_v);
            steady = (ph >= PHASES - 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender keeps offering while the result side is held off
                if (ph == 3 && k == 40) holds_asked++;
                if (ph == 5 && k == 50) settle_block(0);
                offer_pulse(build_pulse(), 1'b0, last_out);
            end
        end

        settle_block(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
